>>> sv/sparse_tap_normalized_filter_macros.svh
// Assertion macros for the sparse-tap normalized filter.
// Included by the top level; no other dependencies.
`ifndef SPARSE_TAP_NORMALIZED_FILTER_MACROS_SVH
`define SPARSE_TAP_NORMALIZED_FILTER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define STNF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stnf same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define STNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stnf next-cycle check failed");
`else
`define STNF_ASSERT_IMP(label, clk, rst, ante, cons)
`define STNF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/stnf_pkg.sv
// Package for the sparse-tap normalized filter: register indexes, microcode
// word type, sequencer step names and the microcode program. No dependencies.
package stnf_pkg;

   localparam int DELAY_BITS     = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int STEP_BITS      = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECURSIVE_MODE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_DIRECT     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_TAP_ONE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_TAP_TWO    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_TAP_THREE  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_TAP_ONE   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_TAP_TWO   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_TAP_THREE = 3'd7;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_WAIT       = 4'd0;
   localparam step_type STEP_READ_ONE   = 4'd1;
   localparam step_type STEP_READ_TWO   = 4'd2;
   localparam step_type STEP_READ_THREE = 4'd3;
   localparam step_type STEP_MUL_LAST   = 4'd4;
   localparam step_type STEP_ACC_LAST   = 4'd5;
   localparam step_type STEP_DIV_LOAD   = 4'd6;
   localparam step_type STEP_DIV_RUN    = 4'd7;
   localparam step_type STEP_OUT_WAIT   = 4'd8;
   localparam step_type STEP_FINISH     = 4'd9;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_TAP_ONE,
      RD_TAP_TWO,
      RD_TAP_THREE
   } rd_sel_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_DIRECT,
      MUL_TAP_ONE,
      MUL_TAP_TWO,
      MUL_TAP_THREE
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_ZERO_W,
      COND_DIV_BUSY,
      COND_OUT_BUSY
   } cond_type;

   // One microcode word. When cond holds the sequencer jumps to target,
   // otherwise it moves to the next step.
   typedef struct packed {
      rd_sel_type  rd_sel;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        div_load;
      logic        div_run;
      logic        finish;
      cond_type    cond;
      step_type    target;
   } ctrl_word_type;

   // The program. Field order: rd_sel, mul_sel, acc_op, div_load, div_run,
   // finish, cond, target.
   function automatic ctrl_word_type ucode_word(input step_type step);
      ctrl_word_type w;
      case (step)
         STEP_WAIT:
            w = '{RD_NONE, MUL_NONE, ACC_HOLD, 1'b0, 1'b0, 1'b0, COND_NO_REQ, STEP_WAIT};
         STEP_READ_ONE:
            w = '{RD_TAP_ONE, MUL_DIRECT, ACC_HOLD, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_WAIT};
         STEP_READ_TWO:
            w = '{RD_TAP_TWO, MUL_TAP_ONE, ACC_LOAD, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_WAIT};
         STEP_READ_THREE:
            w = '{RD_TAP_THREE, MUL_TAP_TWO, ACC_ADD, 1'b0, 1'b0, 1'b0, COND_NEVER,
                  STEP_WAIT};
         STEP_MUL_LAST:
            w = '{RD_NONE, MUL_TAP_THREE, ACC_ADD, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_WAIT};
         STEP_ACC_LAST:
            w = '{RD_NONE, MUL_NONE, ACC_ADD, 1'b0, 1'b0, 1'b0, COND_ZERO_W, STEP_OUT_WAIT};
         STEP_DIV_LOAD:
            w = '{RD_NONE, MUL_NONE, ACC_HOLD, 1'b1, 1'b0, 1'b0, COND_NEVER, STEP_WAIT};
         STEP_DIV_RUN:
            w = '{RD_NONE, MUL_NONE, ACC_HOLD, 1'b0, 1'b1, 1'b0, COND_DIV_BUSY,
                  STEP_DIV_RUN};
         STEP_OUT_WAIT:
            w = '{RD_NONE, MUL_NONE, ACC_HOLD, 1'b0, 1'b0, 1'b0, COND_OUT_BUSY,
                  STEP_OUT_WAIT};
         STEP_FINISH:
            w = '{RD_NONE, MUL_NONE, ACC_HOLD, 1'b0, 1'b0, 1'b1, COND_ALWAYS, STEP_WAIT};
         default:
            w = '{RD_NONE, MUL_NONE, ACC_HOLD, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

>>> sv/sparse_tap_normalized_filter.sv
// Sparse-tap normalized filter, top level: microcoded sequencer, history
// memory, multiply-accumulate and a two-bit-per-cycle divider.
// Depends on stnf_pkg and sparse_tap_normalized_filter_macros.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   req     | in        | req_valid/stall    | req_in_sample, req_block_start
//   rsp     | out       | rsp_valid/stall    | rsp_out_sample, rsp_zero_weight
//   csr     | in        | csr_write_en       | csr_index, csr_wdata
//
// Flow: the result of a transaction is loaded into the output register
// before the next input transaction can be accepted. The divider makes
// ITER = (SAMPLE_BITS + COEF_BITS + 3) / 2 passes (21 with the default
// widths) and retires two quotient bits per cycle. With all coefficients
// zero the divider is skipped.
// Reset is synchronous and active high; it restores the register defaults,
// clears the write position and the sample count. The history memory is not
// cleared: the sample count keeps every read inside written entries.
// A stalled result waits in the output register; the next input transaction
// is accepted meanwhile, and the sequencer only holds before loading its own
// result while the previous one is still stalled.
`include "sparse_tap_normalized_filter_macros.svh"

module sparse_tap_normalized_filter #(
   parameter int HISTORY_DEPTH = 1024,
   parameter int SAMPLE_BITS   = 24,
   parameter int COEF_BITS     = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Input transactions.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [SAMPLE_BITS-1:0]           req_in_sample,
   input  logic                                    req_block_start,
   // Result transactions.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]           rsp_out_sample,
   output logic                                    rsp_zero_weight,
   // Configuration writes.
   input  logic                                    csr_write_en,
   input  logic [stnf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [((COEF_BITS > stnf_pkg::DELAY_BITS) ? COEF_BITS :
                  stnf_pkg::DELAY_BITS)-1:0]       csr_wdata
);
   import stnf_pkg::*;

   // Address and counter widths follow the history depth.
   localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SEEN_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CW     = (SEEN_W > DELAY_BITS) ? SEEN_W : DELAY_BITS;
   // Arithmetic widths follow the sample and coefficient widths.
   localparam int PW     = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W  = PW + 2;
   localparam int WW     = COEF_BITS + 2;
   localparam int ITER   = (ACC_W + 1) / 2;
   localparam int DW     = 2 * ITER;
   localparam int CNT_W  = $clog2(ITER + 1);

   localparam logic [DW-1:0] SAT_POS =
      {{(DW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [DW-1:0] SAT_NEG = SAT_POS + DW'(1);
   localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic                          recursive_mode_ff;
   logic signed [COEF_BITS-1:0]   coef_direct_ff;
   logic signed [COEF_BITS-1:0]   coef_tap_one_ff;
   logic signed [COEF_BITS-1:0]   coef_tap_two_ff;
   logic signed [COEF_BITS-1:0]   coef_tap_three_ff;
   logic [DELAY_BITS-1:0]         delay_tap_one_ff;
   logic [DELAY_BITS-1:0]         delay_tap_two_ff;
   logic [DELAY_BITS-1:0]         delay_tap_three_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         recursive_mode_ff  <= 1'b0;
         coef_direct_ff     <= COEF_BITS'(32'sd16384);
         coef_tap_one_ff    <= '0;
         coef_tap_two_ff    <= '0;
         coef_tap_three_ff  <= '0;
         delay_tap_one_ff   <= DELAY_BITS'(1);
         delay_tap_two_ff   <= DELAY_BITS'(2);
         delay_tap_three_ff <= DELAY_BITS'(3);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RECURSIVE_MODE:  recursive_mode_ff  <= csr_wdata[0];
            CSR_COEF_DIRECT:     coef_direct_ff     <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_TAP_ONE:    coef_tap_one_ff    <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_TAP_TWO:    coef_tap_two_ff    <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_TAP_THREE:  coef_tap_three_ff  <= csr_wdata[COEF_BITS-1:0];
            CSR_DELAY_TAP_ONE:   delay_tap_one_ff   <= csr_wdata[DELAY_BITS-1:0];
            CSR_DELAY_TAP_TWO:   delay_tap_two_ff   <= csr_wdata[DELAY_BITS-1:0];
            CSR_DELAY_TAP_THREE: delay_tap_three_ff <= csr_wdata[DELAY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: step counter, microcode word and jump condition.
   // ---------------------------------------------------------------------
   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type ctrl;
   logic          cond_hit;
   logic          req_accept;

   logic [CNT_W-1:0] div_cnt_ff;
   logic             zero_ff;
   logic             rsp_valid_ff;

   assign ctrl       = ucode_word(step_ff);
   assign req_stall  = (step_ff != STEP_WAIT);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:    cond_hit = 1'b0;
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_NO_REQ:   cond_hit = !req_accept;
         COND_ZERO_W:   cond_hit = zero_ff;
         // The last divider pass runs in the cycle where the count is one.
         COND_DIV_BUSY: cond_hit = (div_cnt_ff != CNT_W'(1));
         COND_OUT_BUSY: cond_hit = rsp_valid_ff && rsp_stall;
         default:       cond_hit = 1'b0;
      endcase
      step_in = cond_hit ? ctrl.target : step_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // ---------------------------------------------------------------------
   // Transaction capture: the sample and the total weight are latched on
   // acceptance, so the coefficient magnitudes are summed only once.
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [WW-1:0]                 weight_ff;
   logic [WW-1:0]                 weight_in;

   function automatic logic [COEF_BITS-1:0] coef_mag(input logic signed [COEF_BITS-1:0] c);
      return c[COEF_BITS-1] ? (~c + COEF_BITS'(1)) : c;
   endfunction

   assign weight_in = WW'(coef_mag(coef_direct_ff)) + WW'(coef_mag(coef_tap_one_ff))
                    + WW'(coef_mag(coef_tap_two_ff)) + WW'(coef_mag(coef_tap_three_ff));

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff      <= req_in_sample;
         weight_ff <= weight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= 1'b0;
      end else if (req_accept) begin
         zero_ff <= (weight_in == '0);
      end
   end

   // ---------------------------------------------------------------------
   // History memory with write position and count of valid past samples.
   // A block start clears the count before any tap is read.
   // ---------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] hist_mem [HISTORY_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [AW-1:0]          wp_ff;
   logic [SEEN_W-1:0]      seen_ff;
   logic [DELAY_BITS-1:0]  rd_delay;
   logic [CW:0]            rd_diff;
   logic [AW-1:0]          rd_addr;
   logic [SAMPLE_BITS-1:0] y_out;
   logic [SAMPLE_BITS-1:0] hist_wdata;

   always_comb begin
      case (ctrl.rd_sel)
         RD_TAP_ONE:   rd_delay = delay_tap_one_ff;
         RD_TAP_TWO:   rd_delay = delay_tap_two_ff;
         RD_TAP_THREE: rd_delay = delay_tap_three_ff;
         default:      rd_delay = delay_tap_one_ff;
      endcase
      // Position delay entries back, modulo the depth.
      if ((CW + 1)'(wp_ff) >= (CW + 1)'(rd_delay)) begin
         rd_diff = (CW + 1)'(wp_ff) - (CW + 1)'(rd_delay);
      end else begin
         rd_diff = (CW + 1)'(wp_ff) + (CW + 1)'(HISTORY_DEPTH) - (CW + 1)'(rd_delay);
      end
      rd_addr = rd_diff[AW-1:0];
   end

   assign hist_wdata = recursive_mode_ff ? y_out : x_ff;

   always_ff @(posedge clock) begin
      if (ctrl.rd_sel != RD_NONE) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         hist_mem[wp_ff] <= hist_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         seen_ff <= '0;
      end else begin
         if (req_accept && req_block_start) begin
            seen_ff <= '0;
         end else if (ctrl.finish && (seen_ff < SEEN_W'(HISTORY_DEPTH))) begin
            seen_ff <= seen_ff + SEEN_W'(1);
         end
         if (ctrl.finish) begin
            wp_ff <= (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Multiply-accumulate. A tap with delay zero takes the current sample;
   // a tap reaching before the block or past the memory adds zero.
   // ---------------------------------------------------------------------
   logic signed [COEF_BITS-1:0]   mul_coef;
   logic signed [SAMPLE_BITS-1:0] mul_opnd;
   logic [DELAY_BITS-1:0]         mul_delay;
   logic [CW-1:0]                 mul_delay_cw;
   logic                          tap_hit;
   logic signed [PW-1:0]          prod_ff;
   logic signed [PW-1:0]          prod_in;
   logic signed [ACC_W-1:0]       acc_ff;

   always_comb begin
      mul_coef  = '0;
      mul_delay = delay_tap_one_ff;
      case (ctrl.mul_sel)
         MUL_DIRECT:    mul_coef = coef_direct_ff;
         MUL_TAP_ONE: begin
            mul_coef  = coef_tap_one_ff;
            mul_delay = delay_tap_one_ff;
         end
         MUL_TAP_TWO: begin
            mul_coef  = coef_tap_two_ff;
            mul_delay = delay_tap_two_ff;
         end
         MUL_TAP_THREE: begin
            mul_coef  = coef_tap_three_ff;
            mul_delay = delay_tap_three_ff;
         end
         default:       mul_coef = '0;
      endcase

      mul_delay_cw = CW'(mul_delay);
      tap_hit = (mul_delay_cw < CW'(HISTORY_DEPTH)) && (mul_delay_cw <= CW'(seen_ff));

      if ((ctrl.mul_sel == MUL_DIRECT) || (mul_delay_cw == '0)) begin
         mul_opnd = x_ff;
      end else if (tap_hit) begin
         mul_opnd = rd_data_ff;
      end else begin
         mul_opnd = '0;
      end

      prod_in = PW'(mul_coef) * PW'(mul_opnd);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (ctrl.acc_op)
         ACC_LOAD: acc_ff <= ACC_W'(prod_ff);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(prod_ff);
         default:  acc_ff <= acc_ff;
      endcase
   end

   // ---------------------------------------------------------------------
   // Restoring divider on magnitudes, two quotient bits per cycle. The
   // quotient shifts into the dividend register; the sign is reapplied after.
   // ---------------------------------------------------------------------
   logic [DW-1:0]    q_ff;
   logic [WW-1:0]    rem_ff;
   logic             neg_ff;
   logic [ACC_W-1:0] acc_mag;
   logic [WW:0]      r_a;
   logic [WW:0]      r_b;
   logic [WW-1:0]    rem_a;
   logic [WW-1:0]    rem_b;
   logic             bit_a;
   logic             bit_b;

   assign acc_mag = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;

   always_comb begin
      r_a   = {rem_ff, q_ff[DW-1]};
      bit_a = (r_a >= (WW + 1)'(weight_ff));
      rem_a = bit_a ? WW'(r_a - (WW + 1)'(weight_ff)) : r_a[WW-1:0];
      r_b   = {rem_a, q_ff[DW-2]};
      bit_b = (r_b >= (WW + 1)'(weight_ff));
      rem_b = bit_b ? WW'(r_b - (WW + 1)'(weight_ff)) : r_b[WW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.div_load) begin
         q_ff   <= DW'(acc_mag);
         rem_ff <= '0;
         neg_ff <= acc_ff[ACC_W-1];
      end else if (ctrl.div_run) begin
         q_ff   <= {q_ff[DW-3:0], bit_a, bit_b};
         rem_ff <= rem_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (ctrl.div_load) begin
         div_cnt_ff <= CNT_W'(ITER);
      end else if (ctrl.div_run) begin
         div_cnt_ff <= div_cnt_ff - CNT_W'(1);
      end
   end

   // Sign, saturation and the zero-weight case.
   logic [DW-1:0] q_neg;

   assign q_neg = ~q_ff + DW'(1);

   always_comb begin
      if (zero_ff) begin
         y_out = '0;
      end else if (neg_ff) begin
         y_out = (q_ff > SAT_NEG) ? OUT_MIN : q_neg[SAMPLE_BITS-1:0];
      end else begin
         y_out = (q_ff > SAT_POS) ? OUT_MAX : q_ff[SAMPLE_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] rsp_out_sample_ff;
   logic                          rsp_zero_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_out_sample_ff  <= y_out;
         rsp_zero_weight_ff <= zero_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_out_sample_ff;
   assign rsp_zero_weight = rsp_zero_weight_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `STNF_ASSERT_IMP(a_finish_out_empty, clock, reset, step_ff == STEP_FINISH, !rsp_valid_ff)
   `STNF_ASSERT_NEXT(a_finish_loads_rsp, clock, reset, step_ff == STEP_FINISH, rsp_valid_ff)
   `STNF_ASSERT_IMP(a_seen_bounded, clock, reset, 1'b1, seen_ff <= SEEN_W'(HISTORY_DEPTH))
   `STNF_ASSERT_IMP(a_div_idle, clock, reset, step_ff == STEP_WAIT, div_cnt_ff == '0)
   `STNF_ASSERT_IMP(a_zero_weight_out, clock, reset, rsp_valid_ff && rsp_zero_weight_ff, rsp_out_sample_ff == '0)

endmodule
